/* hw/rtl/assert_macros.svh */
// assertion helpers included by the heap engine rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/thmh_pkg.sv */
// ----------------------------------------------------------------------------
// thmh_pkg
// Types, constants and ordering helpers of the ternary min-heap unit.
// ----------------------------------------------------------------------------
`default_nettype none

package thmh_pkg;

  localparam int CAPACITY = 4096;
  localparam int ARITY    = 3;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int REM_W   = 13;
  localparam int KEY_W   = 32;
  localparam int AGE_W   = 32;
  localparam int CRD_W   = 15;
  localparam int STAT_W  = 2;
  localparam int CHD_W   = $clog2(ARITY);
  localparam int FIRST_W = IDX_W + $clog2(ARITY) + 1;

  // reciprocal for the parent index, exact for any index below capacity
  localparam int DIV_SH = IDX_W + $clog2(ARITY);
  localparam int RECIP  = (2 ** DIV_SH + ARITY - 1) / ARITY;
  localparam int RCP_W  = DIV_SH + 1;
  localparam int PRD_W  = IDX_W + RCP_W;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [FIRST_W-1:0] first_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [AGE_W-1:0]        age;
    logic [CRD_W-1:0]        row;
    logic [CRD_W-1:0]        col;
  } entry_t;

  typedef struct packed {
    logic                    op;
    logic signed [KEY_W-1:0] key;
    logic [CRD_W-1:0]        row;
    logic [CRD_W-1:0]        col;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [KEY_W-1:0] key;
    logic [CRD_W-1:0]        row;
    logic [CRD_W-1:0]        col;
    logic [REM_W-1:0]        remaining;
  } res_t;

  // lower key first, older insert first on equal keys
  function automatic logic goes_before(entry_t a, entry_t b);
    if (a.key != b.key) begin
      return $signed(a.key) < $signed(b.key);
    end
    return a.age < b.age;
  endfunction

  // (pos - 1) / ARITY by reciprocal multiply
  function automatic idx_t parent_of(idx_t pos);
    logic [PRD_W-1:0] prod;
    prod = PRD_W'(pos - idx_t'(1)) * PRD_W'(RECIP);
    return idx_t'(prod >> DIV_SH);
  endfunction

  function automatic first_t first_child(idx_t pos);
    return first_t'(pos) * first_t'(ARITY) + first_t'(1);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/thmh_engine.sv */
// ----------------------------------------------------------------------------
// thmh_engine
// Heap slot memory and the sequencer that sifts entries up and down it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module thmh_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  thmh_pkg::req_t     req,
  output logic               idle,
  output logic               res_valid,
  input  wire logic          res_ready,
  output thmh_pkg::res_t     res
);
  import thmh_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RCMP  = 9'b000000010,
    S_PUT   = 9'b000000100,
    S_PROOT = 9'b000001000,
    S_PLAST = 9'b000010000,
    S_SREQ  = 9'b000100000,
    S_SDATA = 9'b001000000,
    S_SDEC  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t             state;
  cnt_t               fill;
  logic [AGE_W-1:0]   ins_num;
  idx_t               pos;
  idx_t               up;
  idx_t               cidx;
  idx_t               bidx;
  logic [CHD_W-1:0]   cnt;
  entry_t             carried;
  entry_t             best;
  res_t               res_q;

  entry_t             mem [CAPACITY];
  entry_t             rd_data;
  logic               rd_en;
  idx_t               rd_addr;
  logic               wr_en;
  idx_t               wr_addr;
  entry_t             wr_data;

  logic               is_full;
  logic               rise_win;
  logic               take;
  logic               sink_win;
  logic               more;
  first_t             first;
  entry_t             new_entry;

  assign is_full   = (fill >= cnt_t'(CAPACITY));
  assign rise_win  = goes_before(carried, rd_data);
  assign take      = (cnt == '0) || goes_before(rd_data, best);
  assign sink_win  = goes_before(best, carried);
  assign first     = first_child(pos);
  assign more      = (cnt < CHD_W'(ARITY - 1)) &&
                     ((first_t'(cidx) + first_t'(1)) < first_t'(fill));
  assign new_entry = '{key: req.key, age: ins_num, row: req.row, col: req.col};

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = res_q;

  // slot memory, one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = carried;
    case (state)
      S_IDLE: begin
        if (start && req.op == OP_INSERT && !is_full && fill != '0) begin
          rd_en   = 1'b1;
          rd_addr = parent_of(idx_t'(fill));
        end else if (start && req.op == OP_POP && fill != '0) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      S_RCMP: begin
        wr_en = 1'b1;
        if (rise_win) begin
          wr_data = rd_data;
          if (up != '0) begin
            rd_en   = 1'b1;
            rd_addr = parent_of(up);
          end
        end
      end
      S_PUT: begin
        wr_en = 1'b1;
      end
      S_PROOT: begin
        if (fill != '0) begin
          rd_en   = 1'b1;
          rd_addr = idx_t'(fill);
        end
      end
      S_SREQ: begin
        if (first < first_t'(fill)) begin
          rd_en   = 1'b1;
          rd_addr = idx_t'(first);
        end
      end
      S_SDATA: begin
        if (more) begin
          rd_en   = 1'b1;
          rd_addr = cidx + idx_t'(1);
        end
      end
      S_SDEC: begin
        wr_en   = 1'b1;
        wr_data = sink_win ? best : carried;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fill    <= '0;
      ins_num <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            res_q.key <= '0;
            res_q.row <= '0;
            res_q.col <= '0;
            if (req.op == OP_INSERT) begin
              if (is_full) begin
                res_q.status    <= ST_FULL;
                res_q.remaining <= REM_W'(fill);
                state           <= S_DONE;
              end else begin
                carried         <= new_entry;
                pos             <= idx_t'(fill);
                up              <= parent_of(idx_t'(fill));
                fill            <= fill + cnt_t'(1);
                ins_num         <= ins_num + AGE_W'(1);
                res_q.status    <= ST_OK;
                res_q.remaining <= REM_W'(fill + cnt_t'(1));
                state           <= (fill == '0) ? S_PUT : S_RCMP;
              end
            end else begin
              if (fill == '0) begin
                res_q.status    <= ST_EMPTY;
                res_q.remaining <= REM_W'(fill);
                state           <= S_DONE;
              end else begin
                fill            <= fill - cnt_t'(1);
                res_q.status    <= ST_OK;
                res_q.remaining <= REM_W'(fill - cnt_t'(1));
                state           <= S_PROOT;
              end
            end
          end
        end
        S_RCMP: begin
          if (rise_win) begin
            pos   <= up;
            up    <= parent_of(up);
            state <= (up == '0) ? S_PUT : S_RCMP;
          end else begin
            state <= S_DONE;
          end
        end
        S_PUT: begin
          state <= S_DONE;
        end
        S_PROOT: begin
          res_q.key <= rd_data.key;
          res_q.row <= rd_data.row;
          res_q.col <= rd_data.col;
          state     <= (fill == '0) ? S_DONE : S_PLAST;
        end
        S_PLAST: begin
          carried <= rd_data;
          pos     <= '0;
          state   <= S_SREQ;
        end
        S_SREQ: begin
          cidx  <= idx_t'(first);
          cnt   <= '0;
          state <= (first < first_t'(fill)) ? S_SDATA : S_PUT;
        end
        S_SDATA: begin
          if (take) begin
            best <= rd_data;
            bidx <= cidx;
          end
          cidx  <= cidx + idx_t'(1);
          cnt   <= cnt + CHD_W'(1);
          state <= more ? S_SDATA : S_SDEC;
        end
        S_SDEC: begin
          if (sink_win) begin
            pos   <= bidx;
            state <= S_SREQ;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `ASSERT_CLK(a_fill_range, fill <= cnt_t'(CAPACITY), "fill count beyond capacity")
  `ASSERT_CLK(a_port_clash, !(rd_en && wr_en && rd_addr == wr_addr),
              "read and write hit the same slot")
  `ASSERT_NEXT(a_insert_fill, start && idle && req.op == OP_INSERT && !is_full,
               fill == $past(fill) + cnt_t'(1), "insert did not grow the heap")
  `ASSERT_NEXT(a_pop_fill, start && idle && req.op == OP_POP && fill != '0,
               fill == $past(fill) - cnt_t'(1), "pop did not shrink the heap")

endmodule

`default_nettype wire

/* hw/rtl/ternary_min_heap_age_tiebreak_unit.sv */
// Insert reads the parent slot and compares once per level risen; pop reads the
// root and, if more remain, the last slot, then sinks reading up to ARITY children
// per level; pop on empty and insert on full report status without reading slots.
// One transaction at a time; the registered slot read paces each level, and a
// result may wait in the output register while the next transaction runs.
// Reset empties the heap and zeroes the insertion counter; slots are not cleared.
// ----------------------------------------------------------------------------
// ternary_min_heap_age_tiebreak_unit
// 3-ary min-heap priority queue with oldest-first order on equal keys.
// ----------------------------------------------------------------------------
`default_nettype none

module ternary_min_heap_age_tiebreak_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             op,
  input  wire logic signed [thmh_pkg::KEY_W-1:0] key,
  input  wire logic [thmh_pkg::CRD_W-1:0]       row,
  input  wire logic [thmh_pkg::CRD_W-1:0]       col,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [thmh_pkg::STAT_W-1:0]           status,
  output logic signed [thmh_pkg::KEY_W-1:0]     out_key,
  output logic [thmh_pkg::CRD_W-1:0]            out_row,
  output logic [thmh_pkg::CRD_W-1:0]            out_col,
  output logic [thmh_pkg::REM_W-1:0]            remaining
);
  import thmh_pkg::*;

  req_t req;
  res_t eng_res;
  res_t out_q;
  logic eng_idle;
  logic eng_valid;
  logic eng_ready;

  assign req      = '{op: op, key: key, row: row, col: col};
  assign in_ready = eng_idle;

  // heap engine
  thmh_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && in_ready),
    .req       (req),
    .idle      (eng_idle),
    .res_valid (eng_valid),
    .res_ready (eng_ready),
    .res       (eng_res)
  );

  // output register, freed when the consumer takes the transaction
  assign eng_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_ready) begin
      out_valid <= eng_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_ready && eng_valid) begin
      out_q <= eng_res;
    end
  end

  assign status    = out_q.status;
  assign out_key   = out_q.key;
  assign out_row   = out_q.row;
  assign out_col   = out_q.col;
  assign remaining = out_q.remaining;

endmodule

`default_nettype wire

/* tb/ternary_min_heap_age_tiebreak_unit_tb.sv */
// ----------------------------------------------------------------------------
// ternary_min_heap_age_tiebreak_unit_tb
// Drives inserts and pops through the valid/ready input channel and checks
// each result against the typed row's values or a behavioural priority queue
// kept alongside the block: lowest key first, oldest insert first on equal
// keys. Covers an empty heap, deep heaps, extreme keys and long output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ternary_min_heap_age_tiebreak_unit_tb;
  import thmh_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 3000;
  localparam int RANDOM_ITEMS   = 1125;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    op = OP_INSERT;
  logic signed [KEY_W-1:0] key = '0;
  logic [CRD_W-1:0]        row = '0;
  logic [CRD_W-1:0]        col = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [STAT_W-1:0]       status;
  logic signed [KEY_W-1:0] out_key;
  logic [CRD_W-1:0]        out_row;
  logic [CRD_W-1:0]        out_col;
  logic [REM_W-1:0]        remaining;

  ternary_min_heap_age_tiebreak_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .key(key), .row(row), .col(col),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_key(out_key), .out_row(out_row), .out_col(out_col),
    .remaining(remaining)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow heap contents and expected results
  entry_t          held_entries[$];
  logic [AGE_W-1:0] next_age = '0;
  res_t            pending_results[$];
  int              error_count = 0;
  int              burst_left = 0;
  bit              hold_req = 1'b0;
  bit              hold_done = 1'b0;
  int              hold_cnt = 0;
  int              stall_mode = 0;
  int              mode_cycles = 0;
  int              idle_cycles = 0;

  typedef struct {
    logic              op;
    logic [KEY_W-1:0]  key;
    logic [CRD_W-1:0]  row;
    logic [CRD_W-1:0]  col;
    bit                typed;
    res_t              want;
  } dir_row_t;

  dir_row_t dir_tab[$];

  // apply one transaction to the shadow queue, return the expected result
  function automatic res_t heap_apply(logic o, logic [KEY_W-1:0] k,
                                      logic [CRD_W-1:0] r, logic [CRD_W-1:0] c);
    res_t   res;
    entry_t e;
    int     best;
    res = '0;
    if (o == OP_INSERT) begin
      if (held_entries.size() >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        e.key = k;
        e.age = next_age;
        e.row = r;
        e.col = c;
        held_entries.push_back(e);
        next_age++;
      end
    end else if (held_entries.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < held_entries.size(); i++) begin
        if ($signed(held_entries[i].key) < $signed(held_entries[best].key) ||
            (held_entries[i].key == held_entries[best].key &&
             held_entries[i].age < held_entries[best].age)) begin
          best = i;
        end
      end
      res.key = held_entries[best].key;
      res.row = held_entries[best].row;
      res.col = held_entries[best].col;
      held_entries.delete(best);
    end
    res.remaining = REM_W'(held_entries.size());
    return res;
  endfunction

  // offer one transaction, bursts separated by random gaps
  task automatic send_item(input logic o, input logic [KEY_W-1:0] k,
                           input logic [CRD_W-1:0] r, input logic [CRD_W-1:0] c,
                           input bit typed, input res_t want);
    res_t calc;
    int   gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    op       <= o;
    key      <= k;
    row      <= r;
    col      <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    calc = heap_apply(o, k, r, c);
    pending_results.push_back(typed ? want : calc);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3, 4: return KEY_W'($signed($urandom_range(0, 8)) - 4);
      default: return $urandom();
    endcase
  endfunction

  function automatic void add_row(logic o, logic [KEY_W-1:0] k, logic [CRD_W-1:0] r,
                                  logic [CRD_W-1:0] c, bit typed, logic [STAT_W-1:0] s,
                                  logic [KEY_W-1:0] ek, logic [CRD_W-1:0] er,
                                  logic [CRD_W-1:0] ec, int rem);
    dir_row_t d;
    d.op = o; d.key = k; d.row = r; d.col = c; d.typed = typed;
    d.want.status = s; d.want.key = ek; d.want.row = er; d.want.col = ec;
    d.want.remaining = REM_W'(rem);
    dir_tab.push_back(d);
  endfunction

  // receiver: changing stall pattern plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt  <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (mode_cycles == 0) begin
        stall_mode  <= $urandom_range(0, 3);
        mode_cycles <= $urandom_range(16, 128);
      end else begin
        mode_cycles <= mode_cycles - 1;
      end
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 0);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    res_t exp_res;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected transaction: status %0d key %0d", status, out_key);
          error_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (status !== exp_res.status) begin
            $error("status: expected %0d actual %0d", exp_res.status, status);
            error_count++;
          end
          if (out_key !== exp_res.key) begin
            $error("out_key: expected %0d actual %0d", exp_res.key, out_key);
            error_count++;
          end
          if (out_row !== exp_res.row) begin
            $error("out_row: expected %0d actual %0d", exp_res.row, out_row);
            error_count++;
          end
          if (out_col !== exp_res.col) begin
            $error("out_col: expected %0d actual %0d", exp_res.col, out_col);
            error_count++;
          end
          if (remaining !== exp_res.remaining) begin
            $error("remaining: expected %0d actual %0d", exp_res.remaining, remaining);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    int ins_pct;
    int wait_cycles;

    // directed rows: empty pop, extreme keys, equal-key order
    add_row(OP_POP,    '0,           '0,      '0,      1, ST_EMPTY, '0, '0, '0, 0);
    add_row(OP_INSERT, 32'h7fff_ffff, 15'h7fff, 15'h7fff, 1, ST_OK, '0, '0, '0, 1);
    add_row(OP_INSERT, 32'h8000_0000, '0,      '0,      1, ST_OK, '0, '0, '0, 2);
    add_row(OP_INSERT, '0,           15'h5555, 15'h2aaa, 1, ST_OK, '0, '0, '0, 3);
    add_row(OP_INSERT, '0,           15'h2aaa, 15'h5555, 1, ST_OK, '0, '0, '0, 4);
    add_row(OP_INSERT, 32'hffff_ffff, 15'd1,   15'd2,   1, ST_OK, '0, '0, '0, 5);
    add_row(OP_POP, '0, '0, '0, 1, ST_OK, 32'h8000_0000, '0, '0, 4);
    add_row(OP_POP, '0, '0, '0, 1, ST_OK, 32'hffff_ffff, 15'd1, 15'd2, 3);
    add_row(OP_POP, '0, '0, '0, 1, ST_OK, '0, 15'h5555, 15'h2aaa, 2);
    add_row(OP_POP, '0, '0, '0, 1, ST_OK, '0, 15'h2aaa, 15'h5555, 1);
    add_row(OP_POP, '0, '0, '0, 1, ST_OK, 32'h7fff_ffff, 15'h7fff, 15'h7fff, 0);
    add_row(OP_POP, '0, '0, '0, 1, ST_EMPTY, '0, '0, '0, 0);
    for (int i = 0; i < 5; i++) begin
      add_row(OP_INSERT, 32'd5, CRD_W'(i), CRD_W'(10 - i), 0, ST_OK, '0, '0, '0, 0);
    end
    add_row(OP_INSERT, 32'd4, 15'd77, 15'd88, 0, ST_OK, '0, '0, '0, 0);
    for (int i = 0; i < 7; i++) begin
      add_row(OP_POP, '0, '0, '0, 0, ST_OK, '0, '0, '0, 0);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].op, dir_tab[i].key, dir_tab[i].row, dir_tab[i].col,
                dir_tab[i].typed, dir_tab[i].want);
    end

    // random mix, insert share changing every segment to sweep fill levels
    ins_pct = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 3))
          0:       ins_pct = 25;
          1:       ins_pct = 50;
          2:       ins_pct = 75;
          default: ins_pct = 95;
        endcase
      end
      if (i == RANDOM_ITEMS / 3) begin
        hold_req = 1'b1;
      end
      send_item(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_POP, pick_key(),
                CRD_W'($urandom_range(0, 32767)), CRD_W'($urandom_range(0, 32767)),
                0, '0);
    end

    // pop-heavy tail to drain part of the heap
    for (int i = 0; i < 300; i++) begin
      send_item(($urandom_range(0, 3) == 0) ? OP_INSERT : OP_POP, pick_key(),
                CRD_W'($urandom_range(0, 32767)), CRD_W'($urandom_range(0, 32767)),
                0, '0);
    end
    in_valid <= 1'b0;

    // drain outstanding results, then settle
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 4 * WATCHDOG_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (64) @(posedge clk);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
